FILE: src/ess_pkg.sv
// ----------------------------------------------------------------------------
// ess_pkg
// Shared types and constants for the energy speech segmenter.
// ----------------------------------------------------------------------------
package ess_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int SQUARE_W      = 2 * SAMPLE_W;
  localparam int TIME_W        = 32;
  localparam int ENERGY_W      = 48;
  localparam int BLEN_W        = 13;
  localparam int CFG_DATA_W    = 48;
  localparam int CFG_IDX_W     = 3;
  localparam int MIN_BLOCK     = 64;
  localparam int MAX_BLOCK_DEF = 4096;

  // Register reset values
  localparam logic [BLEN_W-1:0]   BLOCK_LENGTH_RST = BLEN_W'(300);
  localparam logic [ENERGY_W-1:0] ENERGY_THR_RST   = ENERGY_W'(1073741);
  localparam logic [TIME_W-1:0]   MIN_SPEECH_RST   = TIME_W'(3000);
  localparam logic [TIME_W-1:0]   MIN_SILENCE_RST  = TIME_W'(3600);
  localparam logic [TIME_W-1:0]   PAD_RST          = TIME_W'(1200);
  localparam logic [TIME_W-1:0]   ITEM_LENGTH_RST  = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_LENGTH     = 3'd0,
    REG_ENERGY_THRESHOLD = 3'd1,
    REG_MIN_SPEECH       = 3'd2,
    REG_MIN_SILENCE      = 3'd3,
    REG_PAD              = 3'd4,
    REG_ITEM_LENGTH      = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] seg_start;
    logic [TIME_W-1:0] seg_end;
  } seg_item_t;

  typedef struct packed {
    logic [BLEN_W-1:0]   block_length;
    logic [ENERGY_W-1:0] energy_threshold;
    logic [TIME_W-1:0]   min_speech_samples;
    logic [TIME_W-1:0]   min_silence_samples;
    logic [TIME_W-1:0]   pad_samples;
    logic [TIME_W-1:0]   clip_length;
  } cfg_t;

  // Squared sample on its way to the accumulator
  typedef struct packed {
    logic                valid;
    logic                last;
    logic [SQUARE_W-1:0] square;
  } square_t;

  // A run that has just closed
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] run_start;
    logic [TIME_W-1:0] loud_end;
  } close_t;

endpackage

FILE: src/ess_square.sv
// ----------------------------------------------------------------------------
// ess_square
// Input register and sample squarer.
// ----------------------------------------------------------------------------
module ess_square
  import ess_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         adv,
  input  logic         in_valid,
  input  sample_item_t in_item,
  output square_t      sq
);

  logic                       s1_valid;
  sample_item_t               s1_item;
  logic                       sq_valid;
  logic                       sq_last;
  logic [SQUARE_W-1:0]        sq_value;
  logic signed [SQUARE_W-1:0] product;

  assign product = SQUARE_W'(s1_item.sample) * SQUARE_W'(s1_item.sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      sq_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
      sq_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_item  <= in_item;
      sq_last  <= s1_item.last;
      sq_value <= SQUARE_W'(unsigned'(product));
    end
  end

  assign sq = '{valid: sq_valid, last: sq_last, square: sq_value};

endmodule

FILE: src/ess_track.sv
// ----------------------------------------------------------------------------
// ess_track
// Block energy accumulator and speech run tracker.
// ----------------------------------------------------------------------------
module ess_track
  import ess_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    adv,
  input  square_t sq,
  input  cfg_t    cfg,
  output close_t  close
);

  localparam int FILL_W = $clog2(MAX_BLOCK + 1);
  localparam int CMP_W  = (FILL_W > BLEN_W) ? FILL_W : BLEN_W;

  logic [TIME_W-1:0]   sample_count, sample_count_next;
  logic [TIME_W-1:0]   block_start, block_start_next;
  logic [FILL_W-1:0]   block_fill, block_fill_next;
  logic [ENERGY_W-1:0] energy_sum, energy_sum_next;
  logic                run_active, run_active_next;
  logic [TIME_W-1:0]   run_start, run_start_next;
  logic [TIME_W-1:0]   loud_end, loud_end_next;

  logic                close_valid, fire;
  logic [TIME_W-1:0]   close_start, close_end, fire_start, fire_end;

  logic [CMP_W-1:0]    cfg_len, blen;
  logic [FILL_W-1:0]   fill_inc;
  logic [ENERGY_W:0]   energy_wide;
  logic [ENERGY_W-1:0] energy_new;
  logic [TIME_W-1:0]   count_inc;
  logic                blk_done, loud, gap_met;

  // Block length clamped to the supported range
  assign cfg_len = CMP_W'(cfg.block_length);
  always_comb begin
    priority if (cfg_len < CMP_W'(MIN_BLOCK)) begin
      blen = CMP_W'(MIN_BLOCK);
    end else if (cfg_len > CMP_W'(MAX_BLOCK)) begin
      blen = CMP_W'(MAX_BLOCK);
    end else begin
      blen = cfg_len;
    end
  end

  assign fill_inc    = block_fill + FILL_W'(1);
  assign count_inc   = sample_count + TIME_W'(1);
  assign blk_done    = (CMP_W'(fill_inc) >= blen) || sq.last;
  assign energy_wide = {1'b0, energy_sum} + (ENERGY_W + 1)'(sq.square);
  assign energy_new  = energy_wide[ENERGY_W] ? '1 : energy_wide[ENERGY_W-1:0];
  assign loud        = energy_new >= cfg.energy_threshold;
  assign gap_met     = (block_start - loud_end) >= cfg.min_silence_samples;

  always_comb begin
    sample_count_next = sample_count;
    block_start_next  = block_start;
    block_fill_next   = block_fill;
    energy_sum_next   = energy_sum;
    run_active_next   = run_active;
    run_start_next    = run_start;
    loud_end_next     = loud_end;
    fire              = 1'b0;
    fire_start        = run_start;
    fire_end          = loud_end;

    if (adv && sq.valid) begin
      sample_count_next = count_inc;
      block_fill_next   = fill_inc;
      energy_sum_next   = energy_new;

      if (blk_done) begin
        block_fill_next  = '0;
        energy_sum_next  = '0;
        block_start_next = count_inc;
        if (loud) begin
          run_active_next = 1'b1;
          if (!run_active) begin
            run_start_next = block_start;
          end
          loud_end_next = count_inc;
        end else if (run_active && gap_met) begin
          fire            = 1'b1;
          run_active_next = 1'b0;
          run_start_next  = '0;
          loud_end_next   = '0;
        end
      end

      // end of stream: flush any open run, then start a fresh item
      if (sq.last) begin
        if (!fire && run_active_next) begin
          fire       = 1'b1;
          fire_start = run_start_next;
          fire_end   = loud_end_next;
        end
        sample_count_next = '0;
        block_start_next  = '0;
        block_fill_next   = '0;
        energy_sum_next   = '0;
        run_active_next   = 1'b0;
        run_start_next    = '0;
        loud_end_next     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      block_start  <= '0;
      block_fill   <= '0;
      energy_sum   <= '0;
      run_active   <= 1'b0;
      run_start    <= '0;
      loud_end     <= '0;
      close_valid  <= 1'b0;
    end else begin
      sample_count <= sample_count_next;
      block_start  <= block_start_next;
      block_fill   <= block_fill_next;
      energy_sum   <= energy_sum_next;
      run_active   <= run_active_next;
      run_start    <= run_start_next;
      loud_end     <= loud_end_next;
      if (adv) begin
        close_valid <= fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      close_start <= fire_start;
      close_end   <= fire_end;
    end
  end

  assign close = '{valid: close_valid, run_start: close_start, loud_end: close_end};

endmodule

FILE: src/ess_segment.sv
// ----------------------------------------------------------------------------
// ess_segment
// Length check, padding and clamping of closed runs; result register.
// ----------------------------------------------------------------------------
module ess_segment
  import ess_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  close_t    close,
  input  cfg_t      cfg,
  output logic      seg_valid,
  output seg_item_t seg_item
);

  logic              pad_valid;
  logic [TIME_W-1:0] pad_start, pad_end;
  logic              long_enough, keep;
  logic [TIME_W-1:0] start_pad, end_sat, end_clamp;
  logic [TIME_W:0]   end_wide;

  // stage 1: minimum length, padded start (floor 0), padded end (saturated)
  assign long_enough = (close.loud_end - close.run_start) >= cfg.min_speech_samples;
  assign start_pad   = (close.run_start >= cfg.pad_samples) ?
                       close.run_start - cfg.pad_samples : '0;
  assign end_wide    = {1'b0, close.loud_end} + {1'b0, cfg.pad_samples};
  assign end_sat     = end_wide[TIME_W] ? '1 : end_wide[TIME_W-1:0];

  // stage 2: clamp to item length, drop empty segments
  assign end_clamp = (pad_end > cfg.clip_length) ? cfg.clip_length : pad_end;
  assign keep      = end_clamp > pad_start;

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_valid <= 1'b0;
      seg_valid <= 1'b0;
    end else if (adv) begin
      pad_valid <= close.valid && long_enough;
      seg_valid <= pad_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pad_start          <= start_pad;
      pad_end            <= end_sat;
      seg_item.seg_start <= pad_start;
      seg_item.seg_end   <= end_clamp;
    end
  end

endmodule

FILE: src/energy_speech_segmenter.sv
// ----------------------------------------------------------------------------
// energy_speech_segmenter
// Energy-based speech segmenter with hangover: sample in, segment out.
// ----------------------------------------------------------------------------
// Path: a segment passes the input reg, square reg, run tracker reg, pad reg
// and result reg after the sample that closes it. Throughput: one sample per
// cycle unless a segment waits; the squarer and accumulator are pipelined.
// Reset: rst (synchronous) empties the pipe, clears block and run state and
// loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
module energy_speech_segmenter
  import ess_pkg::*;
#(
  parameter int MAX_BLOCK = MAX_BLOCK_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample channel
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  sample_item_t          sample_item,
  // segment channel
  output logic                  seg_valid,
  input  logic                  seg_ready,
  output seg_item_t             seg_item,
  // configuration write port
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg;
  square_t sq;
  close_t  close;
  logic    adv;

  // The whole pipe moves together; it stalls only while a finished segment
  // waits at the output. The result register decouples the two sides, so a
  // new sample is still taken in the cycle the pending segment transfers.
  assign adv          = !seg_valid || seg_ready;
  assign sample_ready = adv;

  // Configuration registers. Writes to unused indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_length        <= BLOCK_LENGTH_RST;
      cfg.energy_threshold    <= ENERGY_THR_RST;
      cfg.min_speech_samples  <= MIN_SPEECH_RST;
      cfg.min_silence_samples <= MIN_SILENCE_RST;
      cfg.pad_samples         <= PAD_RST;
      cfg.clip_length         <= ITEM_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_LENGTH:     cfg.block_length        <= cfg_data[BLEN_W-1:0];
        REG_ENERGY_THRESHOLD: cfg.energy_threshold    <= cfg_data[ENERGY_W-1:0];
        REG_MIN_SPEECH:       cfg.min_speech_samples  <= cfg_data[TIME_W-1:0];
        REG_MIN_SILENCE:      cfg.min_silence_samples <= cfg_data[TIME_W-1:0];
        REG_PAD:              cfg.pad_samples         <= cfg_data[TIME_W-1:0];
        REG_ITEM_LENGTH:      cfg.clip_length         <= cfg_data[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register and 16x16 square
  ess_square u_square (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (sample_valid),
    .in_item  (sample_item),
    .sq       (sq)
  );

  // Saturating block sum of squares, loud/quiet decision, run open/close.
  // A quiet block closes a run once the gap since the last loud end is met;
  // the final sample of the stream flushes any open run and resets indices.
  ess_track #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_track (
    .clk   (clk),
    .rst   (rst),
    .adv   (adv),
    .sq    (sq),
    .cfg   (cfg),
    .close (close)
  );

  // Minimum-length filter, padding, clamp to item length, result register
  ess_segment u_segment (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .close     (close),
    .cfg       (cfg),
    .seg_valid (seg_valid),
    .seg_item  (seg_item)
  );

endmodule

FILE: tb/sv/tb_energy_speech_segmenter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_energy_speech_segmenter
// Self-checking bench: a directed table then phased random audio streams,
// each segment compared field by field with the table or an in-bench predictor.
// ----------------------------------------------------------------------------
module tb_energy_speech_segmenter;
  import ess_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int RESET_CYCLES  = 10;
  // Pipe is 5 stages deep; a sample that makes no segment may still be in
  // flight when the last segment lands, so give it a margin before touching
  // config.
  localparam int SETTLE_CYCLES = 12;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 400000;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;
  typedef enum logic [1:0] {IDLE_SEND_LIGHT, IDLE_RECV_LIGHT, IDLE_NONE} idle_mode_t;

  // One line of the directed table. A sample row repeats its sample `count`
  // times; `last` and any typed-in segment apply to the final repeat only.
  typedef struct {
    row_kind_t         kind;
    cfg_reg_t          reg_idx;
    logic [47:0]       value;
    int                count;
    bit                last;
    bit                typed;
    bit                exp_seg;
    logic [TIME_W-1:0] exp_start;
    logic [TIME_W-1:0] exp_end;
  } dir_row_t;

  // One random phase: a full register set, a sample budget and stream shape
  typedef struct {
    logic [47:0] blen;
    logic [47:0] thr;
    logic [47:0] shortest_run;
    logic [47:0] quiet_gap;
    logic [47:0] pad;
    logic [47:0] item_len;
    int          budget;
    int          min_len;
    int          max_len;
    idle_mode_t  mode;
    bit          pressure;
  } phase_t;

  logic                  clk;
  logic                  rst;
  logic                  sample_valid;
  logic                  sample_ready;
  sample_item_t          sample_item;
  logic                  seg_valid;
  logic                  seg_ready;
  seg_item_t             seg_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  energy_speech_segmenter DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample_item  (sample_item),
    .seg_valid    (seg_valid),
    .seg_ready    (seg_ready),
    .seg_item     (seg_item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Predictor state: a shadow of the register file and of the stream tracker
  // --------------------------------------------------------------------------
  logic [BLEN_W-1:0]   cfg_blen;
  logic [ENERGY_W-1:0] cfg_thr;
  logic [TIME_W-1:0]   cfg_min_speech;
  logic [TIME_W-1:0]   cfg_min_silence;
  logic [TIME_W-1:0]   cfg_pad;
  logic [TIME_W-1:0]   cfg_item_len;

  logic [TIME_W-1:0]   pos;          // index of the next sample
  logic [TIME_W-1:0]   blk_start;
  logic [BLEN_W-1:0]   blk_fill;
  logic [ENERGY_W-1:0] blk_energy;
  bit                  in_run;
  logic [TIME_W-1:0]   run_first;
  logic [TIME_W-1:0]   run_loud_end;

  seg_item_t expected_segs[$];
  dir_row_t  dir_rows[$];
  phase_t    phases[$];
  int        error_count;
  int        cycle_count;
  int        snd_idle_pct;
  int        rcv_idle_pct;
  int        hold_left;
  bit        hold_pending;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("energy_speech_segmenter regression: fail");
      $finish;
    end
  end

  task automatic add_row(input dir_row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic add_phase(input phase_t p);
    phases.insert(phases.size(), p);
  endtask

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Closes the open run: keeps it if long enough, pads, clamps and drops it if
  // it comes out empty. Tracker run state is cleared either way.
  task automatic close_speech_run(output bit kept, output seg_item_t seg);
    logic [TIME_W:0]   padded_end;
    logic [TIME_W-1:0] st;
    logic [TIME_W-1:0] en;
    kept = 1'b0;
    seg  = '0;
    if (in_run && (run_loud_end - run_first) >= cfg_min_speech) begin
      st = (run_first >= cfg_pad) ? run_first - cfg_pad : '0;
      padded_end = {1'b0, run_loud_end} + {1'b0, cfg_pad};
      en = padded_end[TIME_W] ? '1 : padded_end[TIME_W-1:0];
      if (en > cfg_item_len) en = cfg_item_len;
      if (en > st) begin
        kept = 1'b1;
        seg.seg_start = st;
        seg.seg_end   = en;
      end
    end
    in_run       = 1'b0;
    run_first    = '0;
    run_loud_end = '0;
  endtask

  task automatic clear_stream();
    pos          = '0;
    blk_start    = '0;
    blk_fill     = '0;
    blk_energy   = '0;
    in_run       = 1'b0;
    run_first    = '0;
    run_loud_end = '0;
  endtask

  task automatic predict_segment(input sample_item_t it, output bit got,
                                 output seg_item_t seg);
    logic signed [31:0] amp;
    logic [31:0]        sq;
    logic [ENERGY_W:0]  acc;
    logic [BLEN_W-1:0]  blen;
    got = 1'b0;
    seg = '0;
    amp = 32'(it.sample);
    sq  = amp * amp;
    // accumulate with saturation at full scale of the energy register
    acc = {1'b0, blk_energy} + (ENERGY_W + 1)'(sq);
    blk_energy = acc[ENERGY_W] ? '1 : acc[ENERGY_W-1:0];
    blk_fill = blk_fill + BLEN_W'(1);
    pos      = pos + TIME_W'(1);
    // block length outside the legal range acts as the nearest bound
    if (cfg_blen < MIN_BLOCK)
      blen = BLEN_W'(MIN_BLOCK);
    else if (cfg_blen > MAX_BLOCK_DEF)
      blen = BLEN_W'(MAX_BLOCK_DEF);
    else
      blen = cfg_blen;
    // a short final block is judged against the same threshold
    if (blk_fill >= blen || it.last) begin
      if (blk_energy >= cfg_thr) begin
        if (!in_run) begin
          in_run    = 1'b1;
          run_first = blk_start;
        end
        run_loud_end = pos;
      end else if (in_run && (blk_start - run_loud_end) >= cfg_min_silence) begin
        close_speech_run(got, seg);
      end
      blk_start  = pos;
      blk_fill   = '0;
      blk_energy = '0;
    end
    // end of stream flushes any run and starts a fresh item
    if (it.last) begin
      if (!got) close_speech_run(got, seg);
      clear_stream();
    end
  endtask

  // --------------------------------------------------------------------------
  // Drivers: everything changes on the falling edge, sampled on the rising one
  // --------------------------------------------------------------------------
  task automatic write_reg(input cfg_reg_t idx, input logic [47:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_BLOCK_LENGTH:     cfg_blen        = value[BLEN_W-1:0];
      REG_ENERGY_THRESHOLD: cfg_thr         = value[ENERGY_W-1:0];
      REG_MIN_SPEECH:       cfg_min_speech  = value[TIME_W-1:0];
      REG_MIN_SILENCE:      cfg_min_silence = value[TIME_W-1:0];
      REG_PAD:              cfg_pad         = value[TIME_W-1:0];
      REG_ITEM_LENGTH:      cfg_item_len    = value[TIME_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Stop offering, let every owed segment out and the pipe run dry
  task automatic drain_pipe();
    sample_valid <= 1'b0;
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // Offers one sample; on transfer, books the segment it should cause.
  // fixed_exp swaps the predictor's answer for one typed into the table.
  task automatic push_sample(input sample_item_t it, input bit fixed_exp,
                             input bit fixed_got, input seg_item_t fixed_seg);
    bit        got;
    seg_item_t seg;
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample_item  <= it;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
    predict_segment(it, got, seg);
    if (fixed_exp) begin
      got = fixed_got;
      seg = fixed_seg;
    end
    if (got) expected_segs.insert(expected_segs.size(), seg);
    @(negedge clk);
  endtask

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_SEND_LIGHT: begin
        snd_idle_pct = 17;
        rcv_idle_pct = 46;
      end
      IDLE_RECV_LIGHT: begin
        snd_idle_pct = 46;
        rcv_idle_pct = 17;
      end
      default: begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
    endcase
  endtask

  // One stream of speech-like content: randomly loud or quiet stretches
  // around the block size, a little noise in the quiet parts, and now and
  // then a stray end-of-stream mark or a stream left open across a phase.
  task automatic gen_stream(input int min_len, input int max_len, inout int n_items);
    int           left;
    int           region;
    int           blen_eff;
    int           roll;
    bit           loud;
    bit           end_last;
    sample_item_t it;
    blen_eff = (cfg_blen < MIN_BLOCK) ? MIN_BLOCK :
               (cfg_blen > MAX_BLOCK_DEF) ? MAX_BLOCK_DEF : int'(cfg_blen);
    left     = $urandom_range(min_len, max_len);
    end_last = ($urandom_range(0, 9) != 0);
    while (left > 0) begin
      region = $urandom_range(1, 2 * blen_eff);
      if (region > left) region = left;
      loud = 1'($urandom_range(0, 1));
      repeat (region) begin
        roll = $urandom_range(0, 99);
        if (loud || roll < 8)
          it.sample = SAMPLE_W'($urandom);
        else
          it.sample = SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
        it.last = (left == 1 && end_last) || roll == 99;
        push_sample(it, 1'b0, 1'b0, '0);
        left--;
        n_items++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      seg_ready <= 1'b0;
    end else begin
      seg_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Checker: each segment transfer against the oldest booked segment
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    seg_item_t want;
    if (!rst && seg_valid && seg_ready) begin
      if (expected_segs.size() == 0) begin
        $display("%0t: unexpected segment: expected none, got start %0d end %0d",
                 $time, seg_item.seg_start, seg_item.seg_end);
        error_count++;
      end else begin
        want = expected_segs.pop_front();
        if (seg_item.seg_start !== want.seg_start) begin
          $display("%0t: seg_start mismatch: expected %0d, got %0d",
                   $time, want.seg_start, seg_item.seg_start);
          error_count++;
        end
        if (seg_item.seg_end !== want.seg_end) begin
          $display("%0t: seg_end mismatch: expected %0d, got %0d",
                   $time, want.seg_end, seg_item.seg_end);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    dir_row_t     row;
    phase_t       ph;
    sample_item_t it;
    int           n_items;

    rst          = 1'b1;
    sample_valid = 1'b0;
    sample_item  = '0;
    seg_ready    = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = REG_BLOCK_LENGTH;
    cfg_data     = '0;
    error_count  = 0;
    cycle_count  = 0;
    hold_left    = 0;
    hold_pending = 1'b0;
    set_idle(IDLE_SEND_LIGHT);

    cfg_blen        = BLOCK_LENGTH_RST;
    cfg_thr         = ENERGY_THR_RST;
    cfg_min_speech  = MIN_SPEECH_RST;
    cfg_min_silence = MIN_SILENCE_RST;
    cfg_pad         = PAD_RST;
    cfg_item_len    = ITEM_LENGTH_RST;
    clear_stream();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed table. One-sample streams (sample plus end mark) give segments
    // that can be read straight off the register values; longer rows exercise
    // block boundaries, some with typed-in segments and some left to the predictor.
    // kind     reg                   value          cnt last typ seg  start  end
    // reset defaults: single sample is far below the minimum run length
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'h8000, 1, 1, 1, 0, 0, 0});
    add_row('{ROW_CFG, REG_MIN_SPEECH, 48'd0, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_CFG, REG_PAD, 48'd0, 0, 0, 0, 0, 0, 0});
    // most negative sample, then just above and just below default threshold
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'h8000, 1, 1, 1, 1, 0, 1});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd1037, 1, 1, 1, 1, 0, 1});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd1036, 1, 1, 1, 0, 0, 0});
    // padded start saturates at zero
    add_row('{ROW_CFG, REG_PAD, 48'd5, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'h7FFF, 1, 1, 1, 1, 0, 6});
    // end clamps to the item length, then an empty segment is dropped
    add_row('{ROW_CFG, REG_ITEM_LENGTH, 48'd3, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'h7FFF, 1, 1, 1, 1, 0, 3});
    add_row('{ROW_CFG, REG_ITEM_LENGTH, 48'd0, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'h7FFF, 1, 1, 1, 0, 0, 0});
    // padded end saturates at the top of the time range
    add_row('{ROW_CFG, REG_ITEM_LENGTH, 48'hFFFF_FFFF, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_CFG, REG_PAD, 48'hFFFF_FFFF, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'h7FFF, 1, 1, 1, 1, 0,
              32'hFFFF_FFFF});
    // zero threshold: silence is loud; full-scale threshold: nothing is
    add_row('{ROW_CFG, REG_PAD, 48'd0, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_CFG, REG_ENERGY_THRESHOLD, 48'd0, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd0, 1, 1, 1, 1, 0, 1});
    add_row('{ROW_CFG, REG_ENERGY_THRESHOLD, 48'hFFFF_FFFF_FFFF,
              0, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'h7FFF, 1, 1, 1, 0, 0, 0});
    // block length of zero acts as the minimum block; loud block, quiet block
    // closes the run, then a loud short final block
    add_row('{ROW_CFG, REG_ENERGY_THRESHOLD, 48'd1, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_CFG, REG_MIN_SILENCE, 48'd0, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_CFG, REG_BLOCK_LENGTH, 48'd0, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd100, 64, 0, 1, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd0, 64, 0, 1, 1, 0, 64});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd5, 30, 1, 1, 1, 128, 158});
    // block length lowered below the current fill ends the block early
    add_row('{ROW_CFG, REG_BLOCK_LENGTH, 48'd128, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd7, 100, 0, 0, 0, 0, 0});
    add_row('{ROW_CFG, REG_BLOCK_LENGTH, 48'd64, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd0, 1, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd0, 70, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd0, 1, 1, 0, 0, 0, 0});
    // longest minimum run: nothing gets through
    add_row('{ROW_CFG, REG_MIN_SPEECH, 48'hFFFF_FFFF, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_CFG, REG_ENERGY_THRESHOLD, 48'd0, 0, 0, 0, 0, 0, 0});
    add_row('{ROW_SMP, REG_BLOCK_LENGTH, 48'd0, 1, 1, 1, 0, 0, 0});

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      if (row.kind == ROW_CFG) begin
        drain_pipe();
        write_reg(row.reg_idx, row.value);
      end else begin
        for (int k = 0; k < row.count; k++) begin
          it.sample = row.value[SAMPLE_W-1:0];
          it.last   = row.last && (k == row.count - 1);
          push_sample(it, row.typed, row.exp_seg && (k == row.count - 1),
                      '{row.exp_start, row.exp_end});
        end
      end
    end

    // Random phases. Each rewrites the whole register file once the block is
    // idle; a stream left open carries its state into the next setting.
    //  blen             thr                 shortest_run quiet_gap  pad
    //  item_len     budget min max mode pressure
    // block length with junk above its 13 bits: only the low bits count
    add_phase('{48'hABC_0000_2040, 48'd64_000_000, 48'd0, 48'd0, 48'd0,
                48'hFFFF_FFFF, 300, 1, 600, IDLE_SEND_LIGHT, 0});
    add_phase('{48'd100, 48'd1_600_000_000, 48'd150, 48'd64, 48'd30,
                48'd2000, 250, 1, 1500, IDLE_SEND_LIGHT, 0});
    // every block loud and the longest silence: runs end only at end of stream
    add_phase('{48'd64, 48'd0, 48'd0, 48'hFFFF_FFFF, 48'd7,
                48'hFFFF_FFFF, 150, 1, 400, IDLE_SEND_LIGHT, 0});
    add_phase('{48'd300, 48'hFFFF_FFFF_FFFF, 48'd3000, 48'd3600, 48'd1200,
                48'hFFFF_FFFF, 80, 1, 700, IDLE_RECV_LIGHT, 0});
    // block length far above the maximum block acts as the maximum block
    add_phase('{48'd8191, 48'd16_384_000_000, 48'd0, 48'd0, 48'd100,
                48'hFFFF_FFFF, 200, 1, 1200, IDLE_RECV_LIGHT, 0});
    add_phase('{48'd65, 48'd65_000_000, 48'd500, 48'd200, 48'hFFFF_FFFF,
                48'd3000, 250, 1, 1200, IDLE_RECV_LIGHT, 0});
    add_phase('{48'd0, 48'd1, 48'd0, 48'd0, 48'd0,
                48'hFFFF_FFFF, 300, 1, 300, IDLE_NONE, 0});
    // back-pressure: one-sample streams, nearly each a segment, while the
    // receiver holds off long enough for the output side to back up
    add_phase('{48'd64, 48'd1, 48'd0, 48'd0, 48'd0,
                48'hFFFF_FFFF, 150, 1, 1, IDLE_NONE, 1});
    add_phase('{48'd200, 48'd200_000_000, 48'd1000, 48'd0, 48'd50,
                48'hFFFF_FFFF, 200, 1, 1200, IDLE_NONE, 0});

    foreach (phases[p]) begin
      ph = phases[p];
      drain_pipe();
      write_reg(REG_BLOCK_LENGTH, ph.blen);
      write_reg(REG_ENERGY_THRESHOLD, ph.thr);
      write_reg(REG_MIN_SPEECH, ph.shortest_run);
      write_reg(REG_MIN_SILENCE, ph.quiet_gap);
      write_reg(REG_PAD, ph.pad);
      write_reg(REG_ITEM_LENGTH, ph.item_len);
      set_idle(ph.mode);
      if (ph.pressure) hold_pending = 1'b1;
      n_items = 0;
      // the last stream of a phase is cut to what is left of the budget
      while (n_items < ph.budget)
        gen_stream(ph.min_len,
                   (ph.max_len < ph.budget - n_items) ? ph.max_len : ph.budget - n_items,
                   n_items);
    end

    // Wind down: everything owed must arrive, then let the pipe settle
    sample_valid <= 1'b0;
    while (expected_segs.size() != 0) @(posedge clk);
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (expected_segs.size() != 0) begin
      $display("%0t: %0d segments expected but never transferred",
               $time, expected_segs.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("energy_speech_segmenter regression: pass");
    end else begin
      $display("energy_speech_segmenter regression: fail");
    end
    $finish;
  end

endmodule
